// ----- rtl/core/pol_pkg.sv -----
// Package for the positional ordered list: request and status codes, field types.
// No dependencies; imported by positional_ordered_list and its checker.
`timescale 1ns / 1ps
`default_nettype none

package pol_pkg;

  typedef logic [2:0]        req_t;
  typedef logic [1:0]        status_t;
  typedef logic signed [31:0] value_t;
  typedef logic [7:0]        pos_t;

  localparam req_t REQ_INS_HEAD = 3'd0;
  localparam req_t REQ_INS_TAIL = 3'd1;
  localparam req_t REQ_INS_POS  = 3'd2;
  localparam req_t REQ_DEL_HEAD = 3'd3;
  localparam req_t REQ_DEL_TAIL = 3'd4;
  localparam req_t REQ_DEL_POS  = 3'd5;
  localparam req_t REQ_DISPLAY  = 3'd6;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_BADPOS = 2'd1;
  localparam status_t ST_FULL   = 2'd2;
  localparam status_t ST_EMPTY  = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/core/positional_ordered_list.sv -----
// Channel  | Ports                                         | Handshake
// request  | in_req_type, in_item_value, in_position       | start && !busy
// result   | out_entry_value, out_status, out_entry_count, | out_strobe, one cycle each
//          | out_last_of_run                               |
//
// Insert and delete requests may be issued back to back; each gives a single result,
// strobed once it has passed the input stage register and the result stage register.
// Display holds busy until its last entry has been read: the entries rotate past the head
// cell, which is the only read port, one entry per cycle.
// rst_n is synchronous; it empties the list and drops any display in flight.
// The receiver cannot stall; results are never held back.
//
// Ordered list kept as a register array, head at index 0. Depends on pol_pkg.
`timescale 1ns / 1ps
`default_nettype none

module positional_ordered_list
  import pol_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  output logic                            busy,
  input  wire  [2:0]                      in_req_type,
  input  wire  signed [31:0]              in_item_value,
  input  wire  [7:0]                      in_position,
  output logic                            out_strobe,
  output logic signed [31:0]              out_entry_value,
  output logic [1:0]                      out_status,
  output logic [$clog2(DEPTH+1)-1:0]      out_entry_count,
  output logic                            out_last_of_run
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W + 1 > 9) ? CNT_W + 1 : 9;

  typedef logic [CNT_W-1:0] cnt_t;

  // input stage
  logic    vld_r;
  req_t    req_r;
  value_t  val_r;
  pos_t    pos_r;

  // list state
  value_t  entries_r   [DEPTH];
  value_t  entries_nxt [DEPTH];
  cnt_t    cnt_r, cnt_nxt;

  // display run
  logic    disp_busy_r, disp_busy_nxt;
  cnt_t    left_r, left_nxt;

  // result stage
  logic    res_vld;
  value_t  res_val;
  status_t res_st;
  logic    res_last;

  logic    out_strobe_r;
  value_t  out_val_r;
  status_t out_st_r;
  cnt_t    out_cnt_r;
  logic    out_last_r;

  logic    accept;
  logic    do_ins, do_del, do_rot;
  cnt_t    idx;
  logic [CMP_W-1:0] pos_ext, cnt_ext;

  assign busy   = disp_busy_r || (vld_r && (req_r == REQ_DISPLAY));
  assign accept = start && !busy;

  assign pos_ext = CMP_W'(pos_r);
  assign cnt_ext = CMP_W'(cnt_r);

  always_comb begin
    disp_busy_nxt = disp_busy_r;
    left_nxt      = left_r;
    cnt_nxt       = cnt_r;
    res_vld       = 1'b0;
    res_val       = '0;
    res_st        = ST_OK;
    res_last      = 1'b1;
    do_ins        = 1'b0;
    do_del        = 1'b0;
    do_rot        = 1'b0;
    idx           = '0;

    if (disp_busy_r) begin
      res_vld       = 1'b1;
      res_val       = entries_r[0];
      res_last      = (left_r == cnt_t'(1));
      do_rot        = 1'b1;
      left_nxt      = left_r - cnt_t'(1);
      disp_busy_nxt = (left_r != cnt_t'(1));
    end else if (vld_r) begin
      res_vld = 1'b1;
      case (req_r)
        REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
          if (cnt_r >= cnt_t'(DEPTH)) begin
            res_st = ST_FULL;
          end else if (req_r == REQ_INS_HEAD) begin
            do_ins = 1'b1;
            idx    = '0;
          end else if (req_r == REQ_INS_TAIL) begin
            do_ins = 1'b1;
            idx    = cnt_r;
          end else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
            res_st = ST_BADPOS;
          end else begin
            do_ins = 1'b1;
            idx    = CNT_W'(pos_ext - CMP_W'(1));
          end
          if (do_ins) cnt_nxt = cnt_r + cnt_t'(1);
        end
        REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_DEL_POS: begin
          if (cnt_r == '0) begin
            res_st = ST_EMPTY;
          end else if (req_r == REQ_DEL_HEAD) begin
            do_del = 1'b1;
            idx    = '0;
          end else if (req_r == REQ_DEL_TAIL) begin
            do_del = 1'b1;
            idx    = cnt_r - cnt_t'(1);
          end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
            res_st = ST_BADPOS;
          end else begin
            do_del = 1'b1;
            idx    = CNT_W'(pos_ext - CMP_W'(1));
          end
          if (do_del) cnt_nxt = cnt_r - cnt_t'(1);
        end
        REQ_DISPLAY: begin
          if (cnt_r == '0) begin
            res_st = ST_EMPTY;
          end else begin
            res_val       = entries_r[0];
            res_last      = (cnt_r == cnt_t'(1));
            do_rot        = 1'b1;
            left_nxt      = cnt_r - cnt_t'(1);
            disp_busy_nxt = (cnt_r > cnt_t'(1));
          end
        end
        default: begin
          res_st = ST_OK;
        end
      endcase
    end
  end

  // Per-cell next value: each cell picks from itself, a neighbor, the head cell or the new value.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_nxt[i] = entries_r[i];
    end
    if (do_ins) begin
      if (idx == '0) entries_nxt[0] = val_r;
      for (int i = 1; i < DEPTH; i++) begin
        if (cnt_t'(i) == idx)
          entries_nxt[i] = val_r;
        else if (cnt_t'(i) > idx)
          entries_nxt[i] = entries_r[i-1];
      end
    end else if (do_del) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (cnt_t'(i) >= idx) entries_nxt[i] = entries_r[i+1];
      end
    end else if (do_rot) begin
      // circular step over the live region: head goes to the tail slot
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (cnt_t'(i) < cnt_r - cnt_t'(1)) entries_nxt[i] = entries_r[i+1];
      end
      for (int i = 0; i < DEPTH; i++) begin
        if (cnt_t'(i) == cnt_r - cnt_t'(1)) entries_nxt[i] = entries_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= 1'b0;
      cnt_r        <= '0;
      disp_busy_r  <= 1'b0;
      left_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      vld_r        <= accept;
      cnt_r        <= cnt_nxt;
      disp_busy_r  <= disp_busy_nxt;
      left_r       <= left_nxt;
      out_strobe_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      val_r <= in_item_value;
      pos_r <= in_position;
    end
    for (int i = 0; i < DEPTH; i++) begin
      entries_r[i] <= entries_nxt[i];
    end
    out_val_r  <= res_val;
    out_st_r   <= res_st;
    out_cnt_r  <= cnt_nxt;
    out_last_r <= res_last;
  end

  assign out_strobe      = out_strobe_r;
  assign out_entry_value = out_val_r;
  assign out_status      = out_st_r;
  assign out_entry_count = out_cnt_r;
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/core/pol_checker.sv -----
// Port-level checker for positional_ordered_list, attached by bind below.
// Depends on pol_pkg for request and status codes.
`timescale 1ns / 1ps
`default_nettype none

module pol_checker
  import pol_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        start,
  input wire                        busy,
  input wire [2:0]                  in_req_type,
  input wire                        out_strobe,
  input wire [1:0]                  out_status,
  input wire [$clog2(DEPTH+1)-1:0]  out_entry_count,
  input wire                        out_last_of_run
);

  // an edit transaction gives a result marked last of run, after the input and output registers
  a_edit_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type != REQ_DISPLAY) |=> ##1 (out_strobe && out_last_of_run))
    else $error("edit request did not produce a single final result");

  a_disp_first: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == REQ_DISPLAY) |=> ##1 out_strobe)
    else $error("display produced no first result");

  // a display run has no gaps until its last entry
  a_disp_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last_of_run) |=> out_strobe)
    else $error("display run broken before last entry");

  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_EMPTY) |-> (out_entry_count == '0))
    else $error("empty status with nonzero count");

  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_FULL) |-> (int'(out_entry_count) == DEPTH))
    else $error("full status with count below depth");

endmodule

bind positional_ordered_list pol_checker #(.DEPTH(DEPTH)) u_pol_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_req_type     (in_req_type),
  .out_strobe      (out_strobe),
  .out_status      (out_status),
  .out_entry_count (out_entry_count),
  .out_last_of_run (out_last_of_run)
);

`default_nettype wire
